// ----- rtl/lek_pkg.sv -----
// Shared types and constants for the lowest-energy selection block.
// No dependencies; imported by every module under rtl/.
package lek_pkg;

  localparam int unsigned LekMaxEntries = 1024;
  localparam int unsigned LekMaxPicks   = 16;
  localparam int unsigned PickCountW    = 5;
  localparam logic [PickCountW-1:0] PickCountRst = 5'd1;

  typedef struct packed {
    logic [15:0] power_value;
    logic [15:0] perf_value;
    logic        last_entry;
  } lek_in_t;

  typedef struct packed {
    logic [3:0]  rank;
    logic [9:0]  config_index;
    logic [31:0] energy_value;
    logic        found;
    logic        last_pick;
  } lek_out_t;

  typedef enum logic [1:0] {
    LekLoad,
    LekScan,
    LekDrain,
    LekEmit
  } lek_state_e;

  // Controller to datapath
  typedef struct packed {
    logic wr;         // store the accepted item
    logic run_start;  // last item taken, prepare the first pass
    logic scan_rd;    // read one stored entry
    logic emit;       // load the pass result into the output register
    logic run_end;    // empty the set
  } lek_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic last_addr;  // read address points at the final stored entry
    logic last_pass;  // current pass is the final one of the run
    logic slot_free;  // output register can take a result this cycle
  } lek_sts_t;

endpackage

// ----- rtl/lek_ctrl.sv -----
// Sequencer for load, scan and emit phases.
// Depends on lek_pkg for the state enum and the command/status structs.
module lek_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  lek_pkg::lek_sts_t sts_i,
  output lek_pkg::lek_ctl_t ctl_o
);
  import lek_pkg::*;

  lek_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LekLoad;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      LekLoad: begin
        if (in_valid_i && in_last_i) state_d = LekScan;
      end
      LekScan: begin
        if (sts_i.last_addr) state_d = LekDrain;
      end
      LekDrain: begin
        state_d = LekEmit;
      end
      LekEmit: begin
        if (sts_i.slot_free) state_d = sts_i.last_pass ? LekLoad : LekScan;
      end
      default: begin
        state_d = LekLoad;
      end
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      LekLoad: begin
        in_ready_o    = 1'b1;
        ctl_o.wr      = in_valid_i;
        ctl_o.run_start = in_valid_i && in_last_i;
      end
      LekScan: begin
        ctl_o.scan_rd = 1'b1;
      end
      LekDrain: begin
        ctl_o = '0;
      end
      LekEmit: begin
        ctl_o.emit    = sts_i.slot_free;
        ctl_o.run_end = sts_i.slot_free && sts_i.last_pass;
      end
      default: begin
        ctl_o = '0;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.run_end |-> ctl_o.emit)
    else $error("run ended without emitting the final result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == LekDrain) |=> (state_q == LekEmit))
    else $error("drain did not lead to emit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.run_start |=> (state_q == LekScan))
    else $error("scan did not follow the last item");

endmodule

// ----- rtl/lek_dpath.sv -----
// Energy store, scan compare, pass bookkeeping and output register.
// Depends on lek_pkg; driven by lek_ctrl through lek_ctl_t.
module lek_dpath #(
  parameter int unsigned MAX_ENTRIES = lek_pkg::LekMaxEntries,
  parameter int unsigned MAX_PICKS   = lek_pkg::LekMaxPicks
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lek_pkg::lek_in_t                 in_data_i,
  input  logic [lek_pkg::PickCountW-1:0]   cfg_data_i,
  input  logic                             cfg_we_i,
  input  lek_pkg::lek_ctl_t                ctl_i,
  output lek_pkg::lek_sts_t                sts_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output lek_pkg::lek_out_t                out_data_o
);
  import lek_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned PW = $clog2(MAX_PICKS + 1);

  logic [31:0]           energy_mem_q [MAX_ENTRIES];
  logic [31:0]           rd_data_q;
  logic [AW-1:0]         rd_idx_q;
  logic                  rd_valid_q;
  logic [AW-1:0]         addr_q;
  logic [CW-1:0]         count_q;
  logic                  have_q;
  logic [31:0]           best_q;
  logic [AW-1:0]         best_idx_q;
  logic [31:0]           prev_q;
  logic                  bounded_q;
  logic [PW-1:0]         pass_q;
  logic [PW-1:0]         picks_q, picks_d;
  logic [PickCountW-1:0] pick_count_q;
  logic                  out_valid_q;
  lek_out_t              out_q;

  logic                  store_ok;
  logic                  take;
  logic [31:0]           product;

  function automatic logic cfg_q_is_zero(input logic [PickCountW-1:0] v);
    return (v == '0);
  endfunction

  assign store_ok = ctl_i.wr && (count_q < CW'(MAX_ENTRIES));
  assign product  = {16'd0, in_data_i.power_value} * {16'd0, in_data_i.perf_value};

  // Entry beats the running best when above the bound and strictly lower
  assign take = rd_valid_q && (!bounded_q || (rd_data_q > prev_q))
                && (!have_q || (rd_data_q < best_q));

  // Zero means one, anything past the limit saturates
  always_comb begin
    if (cfg_q_is_zero(pick_count_q)) begin
      picks_d = PW'(1);
    end else if (int'(pick_count_q) > int'(MAX_PICKS)) begin
      picks_d = PW'(MAX_PICKS);
    end else begin
      picks_d = PW'(pick_count_q);
    end
  end

  assign sts_o.last_addr = ({{(CW-AW){1'b0}}, addr_q} == (count_q - CW'(1)));
  assign sts_o.last_pass = ((pass_q + PW'(1)) == picks_q);
  assign sts_o.slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (store_ok) begin
      energy_mem_q[count_q[AW-1:0]] <= product;
    end
    if (ctl_i.scan_rd) begin
      rd_data_q <= energy_mem_q[addr_q];
      rd_idx_q  <= addr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_q     <= rd_data_q;
      best_idx_q <= rd_idx_q;
    end
    if (ctl_i.emit) begin
      out_q.rank         <= 4'(pass_q);
      out_q.config_index <= have_q ? 10'(best_idx_q) : 10'd0;
      out_q.energy_value <= have_q ? best_q : 32'd0;
      out_q.found        <= have_q;
      out_q.last_pick    <= sts_o.last_pass;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pick_count_q <= PickCountRst;
      count_q      <= '0;
      addr_q       <= '0;
      rd_valid_q   <= 1'b0;
      have_q       <= 1'b0;
      prev_q       <= '0;
      bounded_q    <= 1'b0;
      pass_q       <= '0;
      picks_q      <= PW'(1);
      out_valid_q  <= 1'b0;
    end else begin
      rd_valid_q <= ctl_i.scan_rd;
      if (cfg_we_i) pick_count_q <= cfg_data_i;
      if (ctl_i.run_end) begin
        count_q <= '0;
      end else if (store_ok) begin
        count_q <= count_q + CW'(1);
      end
      if (ctl_i.scan_rd) addr_q <= addr_q + AW'(1);
      if (take) have_q <= 1'b1;
      if (ctl_i.run_start) begin
        pass_q    <= '0;
        picks_q   <= picks_d;
        bounded_q <= 1'b0;
        addr_q    <= '0;
        have_q    <= 1'b0;
      end
      if (ctl_i.emit) begin
        if (have_q) prev_q <= best_q;
        bounded_q <= 1'b1;
        pass_q    <= pass_q + PW'(1);
        addr_q    <= '0;
        have_q    <= 1'b0;
      end
      if (ctl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result emitted over a pending result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ENTRIES))
    else $error("entry count beyond store depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.scan_rd |-> (count_q != '0))
    else $error("scan over an empty set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.emit && have_q && bounded_q) |-> (best_q > prev_q))
    else $error("pick not above the previous pick");

endmodule

// ----- rtl/lowest_energy_k_select.sv -----
// Lowest-energy selection: loads configurations (power x run time = energy)
// at one item per clock, then after the item flagged last_entry it makes
// pick_count selection passes, each returning the index and energy of the
// smallest energy strictly above the previous pick (ties to the lowest index).
// A pass reads every stored entry through the single read port of the energy
// memory, one entry per cycle, and each pick then waits until the output
// register is free (out_ready_i). Input is not taken while passes run.
// pick_count of 0 acts as 1; values above MAX_PICKS saturate. Items beyond
// MAX_ENTRIES in one set are dropped, though a last_entry flag on such an
// item still starts the run. Depends on lek_pkg, lek_ctrl and lek_dpath.
module lowest_energy_k_select #(
  parameter int unsigned MAX_ENTRIES = lek_pkg::LekMaxEntries,
  parameter int unsigned MAX_PICKS   = lek_pkg::LekMaxPicks
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write: pick_count
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lek_pkg::PickCountW-1:0] cfg_data_i,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  lek_pkg::lek_in_t               in_data_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output lek_pkg::lek_out_t              out_data_o
);
  import lek_pkg::*;

  lek_ctl_t ctl;
  lek_sts_t sts;

  // The user must write the register only while idle; this block does not enforce it, so always take the write
  assign cfg_ready_o = 1'b1;

  lek_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last_entry),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  lek_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_PICKS   (MAX_PICKS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_we_i    (cfg_valid_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
